// ===== rtl/dwca_pkg.sv =====
package dwca_pkg;

  localparam int ENTRY_REGS = 4;
  localparam int ENTRY_W    = 20;
  localparam int ROWS_W     = 11;
  localparam int WIN_W      = 10;
  localparam int STEPC_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ENTRY_W;
  localparam int LC_W       = 32;
  localparam int WEIGHT_W   = 16;
  localparam int OFS_W      = 2;
  localparam int PROD_W     = LC_W + WEIGHT_W;
  localparam int FRAC_SHIFT = 12;
  localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
  localparam int COST_W     = 48;
  localparam int COL_W      = 16;
  localparam int ROWIDX_W   = 10;
  localparam int STEPT_W    = 3;
  localparam int DIFF_W     = COL_W + 1;

  localparam logic [COST_W-1:0] COST_ALL_ONES = '1;
  localparam logic [COL_W-1:0]  COL_MAX       = '1;

  localparam logic [ROWS_W-1:0]  RST_ROWS_IN_USE   = 11'd1024;
  localparam logic [WIN_W-1:0]   RST_WINDOW_SIZE   = 10'd0;
  localparam logic               RST_WINDOW_ENABLE = 1'b0;
  localparam logic [STEPC_W-1:0] RST_STEP_COUNT    = 3'd3;
  localparam logic [ENTRY_W-1:0] RST_STEP_ENTRY_0  = 20'd65541;
  localparam logic [ENTRY_W-1:0] RST_STEP_ENTRY_1  = 20'd65537;
  localparam logic [ENTRY_W-1:0] RST_STEP_ENTRY_2  = 20'd65540;
  localparam logic [ENTRY_W-1:0] RST_STEP_ENTRY_3  = 20'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE   = 3'd0,
    REG_WINDOW_SIZE   = 3'd1,
    REG_WINDOW_ENABLE = 3'd2,
    REG_STEP_COUNT    = 3'd3,
    REG_STEP_ENTRY_0  = 3'd4,
    REG_STEP_ENTRY_1  = 3'd5,
    REG_STEP_ENTRY_2  = 3'd6,
    REG_STEP_ENTRY_3  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [ROWS_W-1:0]                      rows_in_use;
    logic [WIN_W-1:0]                       window_size;
    logic                                   window_enable;
    logic [STEPC_W-1:0]                     step_count;
    logic [ENTRY_REGS-1:0][ENTRY_W-1:0]     step_entry;
  } cfg_t;

endpackage

// ===== rtl/windowed_dtw_cost_accumulator_unit.sv =====
// Accumulates warping costs over a cost matrix whose local costs arrive one
// word per cell, column by column with the row index running fastest.
// The input channel carries a Q16.16 local cost and a start-of-matrix mark;
// the output channel returns one word per input word with the Q32.16
// accumulated cost, the winning step, the cell coordinates and two flags.
// The user must write registers through the configuration port only while
// the block is idle; the block itself does not enforce this. A cell steps
// through the active step entries, none for the start cell and for cells
// outside the band. The cost store has one read port, so one step is issued
// per cycle and each usable step reads one predecessor; its product is formed
// by one multiplier in the same cycle. The result goes to the output register
// once the last step has been compared.
// The output register lets the next word be accepted while a result waits.
// When the receiver stalls, the result is held and the block stops after it
// has finished the following cell, until the output register frees up.
// Reset clears the counters and loads the register defaults; the cost store
// needs no clearing because every entry is written before it is read.
module windowed_dtw_cost_accumulator_unit #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_STEPS  = 4,
  parameter int MAX_OFFSET = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dwca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dwca_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dwca_pkg::LC_W-1:0]         local_cost_i,
  input  logic                              first_of_matrix_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dwca_pkg::COST_W-1:0]       accumulated_cost_o,
  output logic [dwca_pkg::STEPT_W-1:0]      step_taken_o,
  output logic [dwca_pkg::ROWIDX_W-1:0]     row_index_o,
  output logic [dwca_pkg::COL_W-1:0]        col_index_o,
  output logic                              unreachable_o,
  output logic                              outside_window_o
);

  localparam int RW       = $clog2(MAX_ROWS);
  localparam int RING     = MAX_OFFSET + 1;
  localparam int BW       = $clog2(RING);
  localparam int SW       = BW + 2;
  localparam int DEPTH    = MAX_ROWS * RING;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = (RW + 1 > dwca_pkg::ROWS_W) ? RW + 1 : dwca_pkg::ROWS_W;
  localparam int STEP_LIM = (MAX_STEPS < dwca_pkg::ENTRY_REGS) ? MAX_STEPS
                                                               : dwca_pkg::ENTRY_REGS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_WRITE
  } state_e;

  dwca_pkg::cfg_t cfg;

  state_e                             state_q;
  logic [RW-1:0]                      row_q;
  logic [dwca_pkg::COL_W-1:0]         col_q;
  logic [BW-1:0]                      base_q;
  logic [dwca_pkg::STEPC_W-1:0]       nsteps_q;
  logic [dwca_pkg::STEPC_W-1:0]       iss_q;
  logic                               pend_q;
  logic                               found_q;
  logic                               out_valid_q;

  logic [RW-1:0]                      cur_row_q;
  logic [dwca_pkg::COL_W-1:0]         cur_col_q;
  logic [BW-1:0]                      cur_base_q;
  logic [dwca_pkg::LC_W-1:0]          lc_q;
  logic                               outside_q;
  logic [dwca_pkg::STEPT_W-1:0]       pend_k_q;
  logic [dwca_pkg::PROD_W-1:0]        prod_q;
  logic [dwca_pkg::COST_W-1:0]        best_q;
  logic [dwca_pkg::STEPT_W-1:0]       win_q;

  logic [dwca_pkg::COST_W-1:0]        out_cost_q;
  logic [dwca_pkg::STEPT_W-1:0]       out_step_q;
  logic [dwca_pkg::ROWIDX_W-1:0]      out_row_q;
  logic [dwca_pkg::COL_W-1:0]         out_col_q;
  logic                               out_unreach_q;
  logic                               out_outside_q;

  logic                               out_free;
  logic                               accept_ok;
  logic                               in_acc;
  logic                               write_fire;
  logic [CW-1:0]                      rows_eff;
  logic [RW-1:0]                      row_start;
  logic [dwca_pkg::COL_W-1:0]         col_start;
  logic [dwca_pkg::DIFF_W-1:0]        r_ext;
  logic [dwca_pkg::DIFF_W-1:0]        c_ext;
  logic [dwca_pkg::DIFF_W-1:0]        diff;
  logic                               outside_d;
  logic                               start_d;
  logic [dwca_pkg::STEPC_W-1:0]       steps_eff;
  logic                               row_wrap;
  logic [RW-1:0]                      row_next;
  logic [dwca_pkg::COL_W-1:0]         col_next;
  logic [BW-1:0]                      base_next;

  logic [dwca_pkg::ENTRY_W-1:0]       entry;
  logic [dwca_pkg::OFS_W-1:0]         dr;
  logic [dwca_pkg::OFS_W-1:0]         dc;
  logic [dwca_pkg::WEIGHT_W-1:0]      weight;
  logic                               usable;
  logic                               issue;
  logic                               rd_en;
  logic [SW-1:0]                      slot_sum;
  logic [BW-1:0]                      slot;
  logic [RW-1:0]                      rd_row;
  logic [AW-1:0]                      rd_addr;
  logic [AW-1:0]                      wr_addr;
  logic [dwca_pkg::COST_W-1:0]        rd_data;
  logic [dwca_pkg::SCALED_W-1:0]      scaled;
  logic [dwca_pkg::COST_W:0]          sum_ext;
  logic [dwca_pkg::COST_W-1:0]        cand;
  logic                               better;

  dwca_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dwca_cost_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (write_fire),
    .wr_addr_i (wr_addr),
    .wr_data_i (best_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept_ok  = (state_q == ST_IDLE) || ((state_q == ST_WRITE) && out_free);
  assign in_stall_o = !accept_ok;
  assign in_acc     = in_valid_i && accept_ok;
  assign write_fire = (state_q == ST_WRITE) && out_free;

  always_comb begin
    if (cfg.rows_in_use == '0) begin
      rows_eff = CW'(1);
    end else if (CW'(cfg.rows_in_use) > CW'(MAX_ROWS)) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = CW'(cfg.rows_in_use);
    end
  end

  always_comb begin
    if (first_of_matrix_i) begin
      row_start = '0;
      col_start = '0;
    end else begin
      row_start = (CW'(row_q) >= rows_eff) ? '0 : row_q;
      col_start = col_q;
    end
  end

  assign r_ext     = dwca_pkg::DIFF_W'(row_start);
  assign c_ext     = dwca_pkg::DIFF_W'(col_start);
  assign diff      = (r_ext > c_ext) ? (r_ext - c_ext) : (c_ext - r_ext);
  assign outside_d = cfg.window_enable && (diff > dwca_pkg::DIFF_W'(cfg.window_size));
  assign start_d   = (row_start == '0) && (col_start == '0);
  assign steps_eff = (cfg.step_count > dwca_pkg::STEPC_W'(STEP_LIM))
                     ? dwca_pkg::STEPC_W'(STEP_LIM) : cfg.step_count;

  assign row_wrap  = (CW'(row_start) + CW'(1)) >= rows_eff;
  assign row_next  = row_wrap ? '0 : (row_start + RW'(1));
  assign col_next  = (row_wrap && (col_start != dwca_pkg::COL_MAX))
                     ? (col_start + dwca_pkg::COL_W'(1)) : col_start;

  always_comb begin
    if (!row_wrap) begin
      base_next = base_q;
    end else if (base_q == BW'(RING - 1)) begin
      base_next = '0;
    end else begin
      base_next = base_q + BW'(1);
    end
  end

  assign entry  = cfg.step_entry[iss_q[1:0]];
  assign dr     = entry[1:0];
  assign dc     = entry[3:2];
  assign weight = entry[dwca_pkg::ENTRY_W-1:4];

  assign usable = !((dr == '0) && (dc == '0))
                  && (SW'(dc) <= SW'(MAX_OFFSET))
                  && (CW'(cur_row_q) >= CW'(dr))
                  && (cur_col_q >= dwca_pkg::COL_W'(dc));
  assign issue  = (state_q == ST_STEP) && (iss_q < nsteps_q);
  assign rd_en  = issue && usable;

  assign slot_sum = SW'(cur_base_q) + SW'(RING) - SW'(dc);
  assign slot     = (slot_sum >= SW'(RING)) ? BW'(slot_sum - SW'(RING)) : BW'(slot_sum);
  assign rd_row   = cur_row_q - RW'(dr);
  assign rd_addr  = AW'(slot) * AW'(MAX_ROWS) + AW'(rd_row);
  assign wr_addr  = AW'(cur_base_q) * AW'(MAX_ROWS) + AW'(cur_row_q);

  assign scaled  = prod_q[dwca_pkg::PROD_W-1:dwca_pkg::FRAC_SHIFT];
  assign sum_ext = {1'b0, rd_data} + (dwca_pkg::COST_W + 1)'(scaled);
  assign cand    = sum_ext[dwca_pkg::COST_W] ? dwca_pkg::COST_ALL_ONES
                                             : sum_ext[dwca_pkg::COST_W-1:0];
  assign better  = pend_q && (!found_q || (cand < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      nsteps_q    <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        row_q    <= row_next;
        col_q    <= col_next;
        base_q   <= base_next;
        nsteps_q <= (outside_d || start_d) ? '0 : steps_eff;
        iss_q    <= '0;
        pend_q   <= 1'b0;
        found_q  <= start_d && !outside_d;
      end else if (state_q == ST_STEP) begin
        iss_q  <= issue ? (iss_q + dwca_pkg::STEPC_W'(1)) : iss_q;
        pend_q <= rd_en;
        if (better) begin
          found_q <= 1'b1;
        end
      end

      if (write_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (iss_q == nsteps_q) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state_q <= in_acc ? ST_STEP : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_row_q  <= row_start;
      cur_col_q  <= col_start;
      cur_base_q <= base_q;
      lc_q       <= local_cost_i;
      outside_q  <= outside_d;
      best_q     <= (start_d && !outside_d) ? dwca_pkg::COST_W'(local_cost_i)
                                            : dwca_pkg::COST_ALL_ONES;
      win_q      <= '0;
    end else if (state_q == ST_STEP) begin
      prod_q   <= weight * lc_q;
      pend_k_q <= iss_q;
      if (better) begin
        best_q <= cand;
        win_q  <= pend_k_q + dwca_pkg::STEPT_W'(1);
      end
    end

    if (write_fire) begin
      out_cost_q    <= best_q;
      out_step_q    <= found_q ? win_q : '0;
      out_row_q     <= dwca_pkg::ROWIDX_W'(cur_row_q);
      out_col_q     <= cur_col_q;
      out_unreach_q <= !found_q;
      out_outside_q <= outside_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accumulated_cost_o = out_cost_q;
  assign step_taken_o       = out_step_q;
  assign row_index_o        = out_row_q;
  assign col_index_o        = out_col_q;
  assign unreachable_o      = out_unreach_q;
  assign outside_window_o   = out_outside_q;

endmodule

// ===== rtl/dwca_cfg_regs.sv =====
module dwca_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dwca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dwca_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output dwca_pkg::cfg_t                     cfg_o
);

  dwca_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use   <= dwca_pkg::RST_ROWS_IN_USE;
      cfg_q.window_size   <= dwca_pkg::RST_WINDOW_SIZE;
      cfg_q.window_enable <= dwca_pkg::RST_WINDOW_ENABLE;
      cfg_q.step_count    <= dwca_pkg::RST_STEP_COUNT;
      cfg_q.step_entry[0] <= dwca_pkg::RST_STEP_ENTRY_0;
      cfg_q.step_entry[1] <= dwca_pkg::RST_STEP_ENTRY_1;
      cfg_q.step_entry[2] <= dwca_pkg::RST_STEP_ENTRY_2;
      cfg_q.step_entry[3] <= dwca_pkg::RST_STEP_ENTRY_3;
    end else if (cfg_we_i) begin
      unique case (dwca_pkg::cfg_reg_e'(cfg_index_i))
        dwca_pkg::REG_ROWS_IN_USE: begin
          cfg_q.rows_in_use <= cfg_wdata_i[dwca_pkg::ROWS_W-1:0];
        end
        dwca_pkg::REG_WINDOW_SIZE: begin
          cfg_q.window_size <= cfg_wdata_i[dwca_pkg::WIN_W-1:0];
        end
        dwca_pkg::REG_WINDOW_ENABLE: begin
          cfg_q.window_enable <= cfg_wdata_i[0];
        end
        dwca_pkg::REG_STEP_COUNT: begin
          cfg_q.step_count <= cfg_wdata_i[dwca_pkg::STEPC_W-1:0];
        end
        dwca_pkg::REG_STEP_ENTRY_0: begin
          cfg_q.step_entry[0] <= cfg_wdata_i;
        end
        dwca_pkg::REG_STEP_ENTRY_1: begin
          cfg_q.step_entry[1] <= cfg_wdata_i;
        end
        dwca_pkg::REG_STEP_ENTRY_2: begin
          cfg_q.step_entry[2] <= cfg_wdata_i;
        end
        dwca_pkg::REG_STEP_ENTRY_3: begin
          cfg_q.step_entry[3] <= cfg_wdata_i;
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dwca_cost_ram.sv =====
module dwca_cost_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [dwca_pkg::COST_W-1:0]    wr_data_i,
  input  logic                           rd_en_i,
  input  logic [AW-1:0]                  rd_addr_i,
  output logic [dwca_pkg::COST_W-1:0]    rd_data_o
);

  logic [dwca_pkg::COST_W-1:0] mem_q [DEPTH];
  logic [dwca_pkg::COST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dwca_checker.sv =====
module dwca_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [dwca_pkg::COST_W-1:0]       accumulated_cost_o,
  input logic [dwca_pkg::STEPT_W-1:0]      step_taken_o,
  input logic [dwca_pkg::ROWIDX_W-1:0]     row_index_o,
  input logic [dwca_pkg::COL_W-1:0]        col_index_o,
  input logic                              unreachable_o,
  input logic                              outside_window_o
);

  // A cell is still being worked on in the cycle after it is taken.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input taken again right after a word was accepted");

  a_hold_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(accumulated_cost_o) && $stable(row_index_o))
  ) else $error("stalled result word changed or vanished");

  a_unreachable_cost: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unreachable_o) |->
      ((accumulated_cost_o == dwca_pkg::COST_ALL_ONES) && (step_taken_o == '0))
  ) else $error("unreachable cell without saturated cost or with a step");

  a_outside_unreachable: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_window_o) |-> unreachable_o
  ) else $error("cell outside the band reported as reachable");

  a_start_cell_only: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !unreachable_o && (step_taken_o == '0)) |->
      ((row_index_o == '0) && (col_index_o == '0))
  ) else $error("reachable cell without a step away from the start cell");

endmodule

bind windowed_dtw_cost_accumulator_unit dwca_checker u_dwca_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .accumulated_cost_o (accumulated_cost_o),
  .step_taken_o       (step_taken_o),
  .row_index_o        (row_index_o),
  .col_index_o        (col_index_o),
  .unreachable_o      (unreachable_o),
  .outside_window_o   (outside_window_o)
);
